@@ src/ssd_pkg.sv @@
// ----------------------------------------------------------------------------
// ssd_pkg
// Types and constants shared by the sensor stream deframer modules.
// ----------------------------------------------------------------------------
package ssd_pkg;

	localparam int IDX_W = 7;	// fill index and delivery count width
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;
	localparam int ERR_W = 16;
	localparam int CMD_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;

	localparam logic [7:0] HEADER_RESET = 8'd19;
	localparam logic [IDX_W-1:0] LIMIT_RESET = 7'd64;
	localparam logic [7:0] BYTE_MASK = 8'hFF;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_LENGTH  = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_CHECK   = 2'd3
	} parse_phase_t;

	typedef enum logic [1:0] {
		ST_DATA  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_CSUM  = 2'd2,
		ST_OVER  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_READ = 2'd1,
		BK_LOAD = 2'd2
	} back_state_t;

	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		status_t          status;
		logic [7:0]       data_byte;
		logic [5:0]       byte_index;
		logic             last;
		logic [ERR_W-1:0] error_total;
	} res_item_t;

	// frame-end command from the parser to the emitter
	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] count;
		logic [ERR_W-1:0] error_total;
	} cmd_t;

	// payload buffer write port
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [7:0]       data;
	} buf_wr_t;

endpackage

@@ src/ssd_stream_if.sv @@
// ----------------------------------------------------------------------------
// ssd_stream_if
// Valid/ready channel carrying one item of a packed payload type.
// ----------------------------------------------------------------------------
interface ssd_stream_if #(
	parameter type payload_t = logic [7:0]
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ src/ssd_front.sv @@
// ----------------------------------------------------------------------------
// ssd_front
// Frame parser: holds configuration, hunts header, stores payload, checks sum.
// ----------------------------------------------------------------------------
module ssd_front #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ssd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ssd_pkg::CFG_DATA_W-1:0]  cfg_data,
	ssd_stream_if.sink                      rx,
	input  logic                            cmd_full,
	input  logic                            drain_done,
	output logic                            cmd_push,
	output ssd_pkg::cmd_t                   cmd_data,
	output ssd_pkg::buf_wr_t                buf_wr
);

	localparam logic [ssd_pkg::IDX_W-1:0] DEPTH_C = BUFFER_DEPTH[ssd_pkg::IDX_W-1:0];

	ssd_pkg::parse_phase_t phase_q, phase_d;
	logic                        enable_q;
	logic [7:0]                  header_q;
	logic [ssd_pkg::IDX_W-1:0]   limit_q;
	logic [7:0]                  len_q, len_d;
	logic [ssd_pkg::IDX_W-1:0]   fill_q, fill_d;
	logic [7:0]                  sum_q, sum_d;
	logic [ssd_pkg::ERR_W-1:0]   err_q, err_d;
	logic                        pend_q, pend_set;
	logic                        accept;
	logic [7:0]                  b;
	logic [7:0]                  total;
	logic [ssd_pkg::IDX_W-1:0]   count;
	logic [7:0]                  fill_next8;

	assign rx.ready = !cmd_full && !pend_q;
	assign accept = rx.valid && rx.ready;
	assign b = rx.payload.rx_byte;
	assign total = sum_q + b;
	assign count = (fill_q < limit_q) ? fill_q : limit_q;
	assign fill_next8 = {1'b0, fill_q} + 8'd1;

	always_comb begin
		phase_d = phase_q;
		len_d = len_q;
		fill_d = fill_q;
		sum_d = sum_q;
		err_d = err_q;
		pend_set = 1'b0;
		cmd_push = 1'b0;
		cmd_data = '{status: ssd_pkg::ST_OVER, count: '0, error_total: err_q};
		buf_wr = '{en: 1'b0, addr: fill_q, data: b};
		if (accept) begin
			if (!enable_q) begin
				phase_d = ssd_pkg::PH_HEADER;
			end else begin
				unique case (phase_q)
					ssd_pkg::PH_HEADER: begin
						if (b == header_q) begin
							sum_d = b;
							phase_d = ssd_pkg::PH_LENGTH;
						end
					end
					ssd_pkg::PH_LENGTH: begin
						len_d = b;
						fill_d = '0;
						sum_d = total;
						phase_d = (b == 8'd0) ? ssd_pkg::PH_CHECK : ssd_pkg::PH_PAYLOAD;
					end
					ssd_pkg::PH_PAYLOAD: begin
						if (fill_q < DEPTH_C && {1'b0, fill_q} < len_q) begin
							buf_wr.en = 1'b1;
							fill_d = fill_q + 1'b1;
							sum_d = total;
							if (fill_next8 >= len_q) begin
								phase_d = ssd_pkg::PH_CHECK;
							end
						end else begin
							phase_d = ssd_pkg::PH_HEADER;
							cmd_push = 1'b1;
						end
					end
					ssd_pkg::PH_CHECK: begin
						phase_d = ssd_pkg::PH_HEADER;
						cmd_push = 1'b1;
						if (total != 8'd0) begin
							err_d = err_q + 1'b1;
							cmd_data.status = ssd_pkg::ST_CSUM;
							cmd_data.error_total = err_d;
						end else if (count == '0) begin
							cmd_data.status = ssd_pkg::ST_EMPTY;
						end else begin
							cmd_data.status = ssd_pkg::ST_DATA;
							cmd_data.count = count;
							pend_set = 1'b1;
						end
					end
					default: phase_d = ssd_pkg::PH_HEADER;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ssd_pkg::PH_HEADER;
			len_q <= '0;
			fill_q <= '0;
			sum_q <= '0;
			err_q <= '0;
			pend_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			len_q <= len_d;
			fill_q <= fill_d;
			sum_q <= sum_d;
			err_q <= err_d;
			// hold off input until the buffer has been read out
			if (pend_set) begin
				pend_q <= 1'b1;
			end else if (drain_done) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			header_q <= ssd_pkg::HEADER_RESET;
			limit_q <= ssd_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ssd_pkg::CFG_ENABLE: enable_q <= cfg_data[0];
				ssd_pkg::CFG_HEADER: header_q <= cfg_data & ssd_pkg::BYTE_MASK;
				ssd_pkg::CFG_LIMIT:  limit_q <= cfg_data[ssd_pkg::IDX_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

@@ src/ssd_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// ssd_cmd_fifo
// Two-entry queue of frame-end commands between parser and emitter.
// ----------------------------------------------------------------------------
module ssd_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ssd_pkg::cmd_t push_data,
	input  logic          pop,
	output ssd_pkg::cmd_t head,
	output logic          empty,
	output logic          full
);

	localparam int PW = (ssd_pkg::CMD_DEPTH > 1) ? $clog2(ssd_pkg::CMD_DEPTH) : 1;
	localparam int CW = $clog2(ssd_pkg::CMD_DEPTH + 1);

	ssd_pkg::cmd_t mem_q [ssd_pkg::CMD_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign empty = (cnt_q == '0);
	assign full = (cnt_q == CW'(ssd_pkg::CMD_DEPTH));
	assign head = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(ssd_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(ssd_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
		end
	end

endmodule

@@ src/ssd_back.sv @@
// ----------------------------------------------------------------------------
// ssd_back
// Emitter: owns the payload buffer and turns commands into result items.
// ----------------------------------------------------------------------------
module ssd_back #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ssd_pkg::buf_wr_t buf_wr,
	input  ssd_pkg::cmd_t    cmd_head,
	input  logic             cmd_empty,
	output logic             cmd_pop,
	output logic             drain_done,
	ssd_stream_if.source     res
);

	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

	logic [7:0] mem [BUFFER_DEPTH];
	logic [7:0] rd_data_q;
	logic       rd_en;

	ssd_pkg::back_state_t state_q, state_d;
	logic [ssd_pkg::IDX_W-1:0] idx_q, idx_d;
	logic [ssd_pkg::IDX_W-1:0] cnt_q, cnt_d;
	logic [ssd_pkg::ERR_W-1:0] err_q, err_d;
	logic                      out_valid_q;
	ssd_pkg::res_item_t        out_q, out_d;
	logic                      load;
	logic                      slot_free;
	logic                      is_last;

	assign slot_free = !out_valid_q || res.ready;
	assign res.valid = out_valid_q;
	assign res.payload = out_q;
	assign is_last = (idx_q + 1'b1) == cnt_q;

	always_ff @(posedge clk) begin
		if (buf_wr.en) begin
			mem[buf_wr.addr[AW-1:0]] <= buf_wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[idx_q[AW-1:0]];
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		cnt_d = cnt_q;
		err_d = err_q;
		rd_en = 1'b0;
		load = 1'b0;
		cmd_pop = 1'b0;
		drain_done = 1'b0;
		out_d = '{status: cmd_head.status, data_byte: '0, byte_index: '0,
			last: 1'b1, error_total: cmd_head.error_total};
		unique case (state_q)
			ssd_pkg::BK_IDLE: begin
				if (!cmd_empty) begin
					if (cmd_head.status == ssd_pkg::ST_DATA) begin
						cmd_pop = 1'b1;
						idx_d = '0;
						cnt_d = cmd_head.count;
						err_d = cmd_head.error_total;
						state_d = ssd_pkg::BK_READ;
					end else if (slot_free) begin
						cmd_pop = 1'b1;
						load = 1'b1;
					end
				end
			end
			ssd_pkg::BK_READ: begin
				rd_en = 1'b1;
				state_d = ssd_pkg::BK_LOAD;
			end
			ssd_pkg::BK_LOAD: begin
				out_d = '{status: ssd_pkg::ST_DATA, data_byte: rd_data_q,
					byte_index: idx_q[5:0], last: is_last, error_total: err_q};
				if (slot_free) begin
					load = 1'b1;
					idx_d = idx_q + 1'b1;
					if (is_last) begin
						drain_done = 1'b1;
						state_d = ssd_pkg::BK_IDLE;
					end else begin
						state_d = ssd_pkg::BK_READ;
					end
				end
			end
			default: state_d = ssd_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssd_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		cnt_q <= cnt_d;
		err_q <= err_d;
		if (load) begin
			out_q <= out_d;
		end
	end

endmodule

@@ src/sensor_stream_deframer.sv @@
// ----------------------------------------------------------------------------
// sensor_stream_deframer
// Header/length/payload/checksum deframer for a received serial byte stream.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake        contents
//  rx       in   valid/ready      rx_byte, one received byte per item
//  res      out  valid/ready      status, data_byte, byte_index, last, error_total
//  cfg      in   cfg_we           cfg_index selects enable, header_byte, out_limit
//
//  A byte that causes no result or a single status result does not stop input.
//  A valid frame delivering n bytes stops input until they have been read out: the
//  buffer has one registered read port, and each byte needs a read then a load.
//  Reset clears FSM and queue state; the payload buffer needs no clearing pass.
//  A stalled res channel holds its item; rx stalls only when the command queue
//  is full or a payload drain is in progress.
//
module sensor_stream_deframer #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ssd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssd_pkg::CFG_DATA_W-1:0] cfg_data,
	ssd_stream_if.sink                     rx,
	ssd_stream_if.source                   res
);

	ssd_pkg::cmd_t    cmd_push_data;
	ssd_pkg::cmd_t    cmd_head;
	ssd_pkg::buf_wr_t buf_wr;
	logic             cmd_push, cmd_pop, cmd_empty, cmd_full;
	logic             drain_done;

	// parse bytes, write payload, issue a command at each frame end
	ssd_front #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.rx(rx),
		.cmd_full(cmd_full),
		.drain_done(drain_done),
		.cmd_push(cmd_push),
		.cmd_data(cmd_push_data),
		.buf_wr(buf_wr)
	);

	// decouple parser and emitter so short status items queue up
	ssd_cmd_fifo u_cmd_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(cmd_push),
		.push_data(cmd_push_data),
		.pop(cmd_pop),
		.head(cmd_head),
		.empty(cmd_empty),
		.full(cmd_full)
	);

	// read out the buffer and drive result items
	ssd_back #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.buf_wr(buf_wr),
		.cmd_head(cmd_head),
		.cmd_empty(cmd_empty),
		.cmd_pop(cmd_pop),
		.drain_done(drain_done),
		.res(res)
	);

endmodule
